// ===== rtl/core/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared job type, pad character constant and alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic        dec;
		logic [23:0] word;
		logic [2:0]  nres;
		logic [2:0]  nreal;
		logic        last;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26)
			c = 8'h41 + {2'b00, s};
		else if (s < 6'd52)
			c = 8'h61 + {2'b00, s - 6'd26};
		else if (s < 6'd62)
			c = 8'h30 + {2'b00, s - 6'd52};
		else if (s == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

	// bit 6 set marks pad or a character outside the alphabet
	function automatic logic [6:0] char_sextet(input logic [7:0] c);
		logic [6:0] s;
		if (c >= 8'h41 && c <= 8'h5A)
			s = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			s = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			s = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			s = 7'd62;
		else if (c == 8'h2F)
			s = 7'd63;
		else
			s = 7'd64;
		return s;
	endfunction

endpackage

// ===== rtl/core/b64_ifs.sv =====
// ----------------------------------------------------------------------------
// Base64 codec channel interfaces
// Valid/ready request channels for input items and result items.
// ----------------------------------------------------------------------------
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_last,
		output ready);
endinterface

// ===== rtl/core/b64_front.sv =====
// ----------------------------------------------------------------------------
// Base64 front end
// Accepts requests, tracks the pending group and builds a job when a group completes or a request is last.
// ----------------------------------------------------------------------------
module b64_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           q_full,
	output logic           push,
	output b64_pkg::job_t  job
);

	logic        direction_q;
	logic [17:0] bits_q;
	logic [1:0]  cnt_q;
	logic        halted_q;

	logic        accept;
	logic [17:0] nbits;
	logic [1:0]  ncnt;
	logic        nhalt;
	logic [6:0]  sx;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign sx       = b64_pkg::char_sextet(in_byte);

	always_comb begin
		job       = '0;
		job.dec   = direction_q;
		job.last  = in_last;
		nbits     = bits_q;
		ncnt      = cnt_q;
		nhalt     = halted_q;
		if (!direction_q) begin
			if (cnt_q >= 2'd2) begin
				job.word  = {bits_q[15:0], in_byte};
				job.nres  = 3'd4;
				job.nreal = 3'd4;
				nbits     = '0;
				ncnt      = 2'd0;
			end else begin
				nbits = {bits_q[9:0], in_byte};
				ncnt  = cnt_q + 2'd1;
				if (in_last) begin
					job.nres = 3'd4;
					if (cnt_q == 2'd0) begin
						job.word  = {in_byte, 16'h0000};
						job.nreal = 3'd2;
					end else begin
						job.word  = {bits_q[7:0], in_byte, 8'h00};
						job.nreal = 3'd3;
					end
				end
			end
		end else begin
			if (!halted_q) begin
				if (sx[6]) begin
					nhalt = 1'b1;
				end else if (cnt_q == 2'd3) begin
					job.word = {bits_q, sx[5:0]};
					job.nres = 3'd3;
					nbits    = '0;
					ncnt     = 2'd0;
				end else begin
					nbits = {bits_q[11:0], sx[5:0]};
					ncnt  = cnt_q + 2'd1;
				end
			end
			if (in_last) begin
				if (ncnt == 2'd2) begin
					job.word = {nbits[11:0], 12'h000};
					job.nres = 3'd1;
				end else if (ncnt == 2'd3) begin
					job.word = {nbits, 6'h00};
					job.nres = 3'd2;
				end
			end
		end
	end

	assign push = accept && ((job.nres != 3'd0) || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			bits_q      <= '0;
			cnt_q       <= 2'd0;
			halted_q    <= 1'b0;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
			bits_q      <= '0;
			cnt_q       <= 2'd0;
			halted_q    <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				bits_q   <= '0;
				cnt_q    <= 2'd0;
				halted_q <= 1'b0;
			end else begin
				bits_q   <= nbits;
				cnt_q    <= ncnt;
				halted_q <= nhalt;
			end
		end
	end

endmodule

// ===== rtl/core/b64_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 job queue
// Small first-in first-out buffer of jobs between front and back ends.
// ----------------------------------------------------------------------------
module b64_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64_pkg::job_t  push_job,
	input  logic           pop,
	output b64_pkg::job_t  head,
	output logic           empty,
	output logic           full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/b64_back.sv =====
// ----------------------------------------------------------------------------
// Base64 back end
// Walks the head job one result per cycle, while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module b64_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64_pkg::job_t  head,
	input  logic           empty,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [7:0]     res_byte,
	output logic           res_data,
	output logic           res_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       data_q;
	logic       last_q;

	logic       load;
	logic       final_res;
	logic [5:0] sext;
	logic [7:0] nbyte;
	logic       ndata;

	assign load      = !empty && (!valid_q || res_ready);
	assign final_res = (head.nres == 3'd0) || (({1'b0, idx_q} + 3'd1) == head.nres);
	assign pop       = load && final_res;

	always_comb begin
		case (idx_q)
			2'd0:    sext = head.word[23:18];
			2'd1:    sext = head.word[17:12];
			2'd2:    sext = head.word[11:6];
			default: sext = head.word[5:0];
		endcase
		ndata = 1'b1;
		if (head.nres == 3'd0) begin
			nbyte = 8'h00;
			ndata = 1'b0;
		end else if (head.dec) begin
			case (idx_q)
				2'd0:    nbyte = head.word[23:16];
				2'd1:    nbyte = head.word[15:8];
				default: nbyte = head.word[7:0];
			endcase
		end else if ({1'b0, idx_q} < head.nreal) begin
			nbyte = b64_pkg::sextet_char(sext);
		end else begin
			nbyte = b64_pkg::PAD_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_res ? 2'd0 : idx_q + 2'd1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nbyte;
			data_q <= ndata;
			last_q <= head.last && final_res;
		end
	end

	assign res_valid = valid_q;
	assign res_byte  = byte_q;
	assign res_data  = data_q;
	assign res_last  = last_q;

endmodule

// ===== rtl/core/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// Base64 stream codec, top level
// A request's first result is registered in the job queue and then in the output register.
// Throughput: one request per cycle in while the job queue has room; one result per cycle out of the output register.
// Encoding gives four results per three requests, so input is held back by the output
// once the job queue fills; decoding takes one character per cycle while the queue has room.
// Reset clears the group state, the job queue and the output stage; direction is encode.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	b64_in_if.sink      feed,
	b64_out_if.source   result
);

	b64_pkg::job_t push_job;
	b64_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (feed.valid),
		.in_ready  (feed.ready),
		.in_byte   (feed.in_byte),
		.in_last   (feed.in_last),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_byte  (result.out_byte),
		.res_data  (result.out_valid),
		.res_last  (result.out_last)
	);

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.out_valid |-> result.out_last)
		else $error("end marker without last flag");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.out_valid |-> result.out_byte == 8'h00)
		else $error("end marker carries a non-zero byte");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Base64 stream codec testbench
// Sends byte and character requests in both directions, with random gaps on
// both channels and a long result stall. Every result symbol is predicted
// and compared in order, field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       fin;
	} symbol_t;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic DIR_ENCODE    = 1'b0;
	localparam logic DIR_DECODE    = 1'b1;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   MAX_PRINTS    = 30;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	b64_in_if  feed_if ();
	b64_out_if result_if ();

	base64_stream_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.feed      (feed_if),
		.result    (result_if)
	);

	symbol_t     owed_symbols[$];
	logic        codec_dir;
	logic [17:0] group_bits;
	logic [1:0]  group_count;
	logic        halted;

	int errors        = 0;
	int requests_sent = 0;
	int hold_left     = 0;
	bit gaps_on       = 1'b1;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
		return ALPHABET[8 * (63 - int'(s)) +: 8];
	endfunction

	function automatic int char_to_sextet(input logic [7:0] c);
		for (int k = 0; k < 64; k++)
			if (ALPHABET[8 * (63 - k) +: 8] == c)
				return k;
		return 64;
	endfunction

	function automatic void clear_group();
		group_bits  = '0;
		group_count = '0;
		halted      = 1'b0;
	endfunction

	function automatic void predict_codec(input logic [7:0] b, input logic fin);
		symbol_t     batch[$];
		logic [23:0] w;
		int          s;
		if (codec_dir == DIR_ENCODE) begin
			if (group_count >= 2) begin
				w = {group_bits[15:0], b};
				for (int k = 0; k < 4; k++)
					batch.push_back(symbol_t'{sextet_to_char(w[23 - 6*k -: 6]), 1'b1, 1'b0});
				group_bits  = '0;
				group_count = '0;
			end else begin
				group_bits  = {group_bits[9:0], b};
				group_count = group_count + 2'd1;
			end
			if (fin && group_count != 0) begin
				w = {6'd0, group_bits} << (8 * (3 - int'(group_count)));
				for (int k = 0; k < 4; k++) begin
					if (k <= group_count)
						batch.push_back(symbol_t'{sextet_to_char(w[23 - 6*k -: 6]), 1'b1, 1'b0});
					else
						batch.push_back(symbol_t'{b64_pkg::PAD_CHAR, 1'b1, 1'b0});
				end
			end
		end else begin
			if (!halted) begin
				s = char_to_sextet(b);
				if (s > 63) begin
					halted = 1'b1;
				end else if (group_count == 2'd3) begin
					w = {group_bits, s[5:0]};
					batch.push_back(symbol_t'{w[23:16], 1'b1, 1'b0});
					batch.push_back(symbol_t'{w[15:8], 1'b1, 1'b0});
					batch.push_back(symbol_t'{w[7:0], 1'b1, 1'b0});
					group_bits  = '0;
					group_count = '0;
				end else begin
					group_bits  = {group_bits[11:0], s[5:0]};
					group_count = group_count + 2'd1;
				end
			end
			if (fin && group_count >= 2) begin
				w = {6'd0, group_bits} << (6 * (4 - int'(group_count)));
				for (int k = 0; k + 1 < group_count; k++)
					batch.push_back(symbol_t'{w[23 - 8*k -: 8], 1'b1, 1'b0});
			end
		end
		if (fin) begin
			if (batch.size() == 0)
				batch.push_back(symbol_t'{8'h00, 1'b0, 1'b1});
			else
				batch[batch.size() - 1].fin = 1'b1;
			clear_group();
		end
		foreach (batch[k])
			owed_symbols.push_back(batch[k]);
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < MAX_PRINTS)
			$display("%0t ns mismatch: %s", $time, what);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// result side: hold off on request, otherwise random stalls
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (gaps_on && $urandom_range(99) < 28)
				result_if.ready <= 1'b0;
			else
				result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		symbol_t got;
		symbol_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = symbol_t'{result_if.out_byte, result_if.out_valid, result_if.out_last};
			if (owed_symbols.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h valid %0b last %0b",
					got.data, got.has_data, got.fin));
			end else begin
				want = owed_symbols.pop_front();
				if (got.data !== want.data)
					report_mismatch($sformatf("out_byte %02h, predicted %02h",
						got.data, want.data));
				if (got.has_data !== want.has_data)
					report_mismatch($sformatf("out_valid %0b, predicted %0b",
						got.has_data, want.has_data));
				if (got.fin !== want.fin)
					report_mismatch($sformatf("out_last %0b, predicted %0b",
						got.fin, want.fin));
			end
		end
	end

	task automatic send_request(input logic [7:0] b, input logic fin);
		while (gaps_on && $urandom_range(99) < 28) begin
			feed_if.valid <= 1'b0;
			@(negedge clk);
		end
		feed_if.valid   <= 1'b1;
		feed_if.in_byte <= b;
		feed_if.in_last <= fin;
		do @(posedge clk); while (!feed_if.ready);
		predict_codec(b, fin);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		feed_if.valid <= 1'b0;
		while (owed_symbols.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(input logic d);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
		codec_dir = d;
		clear_group();
		@(negedge clk);
	endtask

	task automatic send_seq(input logic [7:0] seq[$], input logic closed);
		foreach (seq[k])
			send_request(seq[k], closed && k == seq.size() - 1);
	endtask

	task automatic send_text(input string t, input logic closed);
		for (int k = 0; k < t.len(); k++)
			send_request(t[k], closed && k == t.len() - 1);
	endtask

	task automatic encode_message(input int len);
		for (int k = 0; k < len; k++)
			send_request(8'($urandom_range(255)), k == len - 1);
	endtask

	// mostly well-formed text, some with one bad character, the rest noise
	task automatic decode_message(input int len);
		int         pick;
		int         bad_at;
		int         total;
		logic [7:0] c;
		pick   = $urandom_range(99);
		bad_at = (pick >= 70 && pick < 88) ? $urandom_range(len - 1) : -1;
		total  = (pick < 70 && len % 4 != 0) ? len + 4 - len % 4 : len;
		for (int k = 0; k < total; k++) begin
			if (k >= len)
				c = b64_pkg::PAD_CHAR;
			else if (pick >= 88)
				c = 8'($urandom_range(255));
			else if (k == bad_at)
				c = ($urandom_range(3) == 0) ? b64_pkg::PAD_CHAR : 8'($urandom_range(255));
			else
				c = sextet_to_char(6'($urandom_range(63)));
			send_request(c, k == total - 1);
		end
	endtask

	task automatic test_encode_directed();
		write_direction(DIR_ENCODE);
		send_seq('{8'h00}, 1'b1);
		send_seq('{8'hFF, 8'hFF}, 1'b1);
		send_seq('{8'h4D, 8'h61, 8'h6E}, 1'b1);
		send_seq('{8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b1);
		send_seq('{8'h12, 8'h34}, 1'b0);
		// drop the pending pair by rewriting the same direction
		write_direction(DIR_ENCODE);
		send_seq('{8'hAB}, 1'b1);
	endtask

	task automatic test_decode_directed();
		write_direction(DIR_DECODE);
		send_text("Az09+/", 1'b1);
		send_text("TQ=x", 1'b1);
		send_text("T", 1'b1);
		send_seq('{8'hFF}, 1'b1);
	endtask

	task automatic test_backpressure();
		write_direction(DIR_ENCODE);
		hold_left = 80;
		repeat (8) encode_message(3);
		write_direction(DIR_DECODE);
		hold_left = 80;
		repeat (6) decode_message(8);
	endtask

	task automatic test_random(input int quota);
		int first;
		first = requests_sent;
		while (requests_sent - first < quota) begin
			write_direction(1'($urandom_range(1)));
			gaps_on = !(requests_sent - first >= quota / 3 &&
				requests_sent - first < quota / 2);
			repeat ($urandom_range(3, 8)) begin
				if (codec_dir == DIR_ENCODE)
					encode_message($urandom_range(1, 9));
				else
					decode_message($urandom_range(1, 12));
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = 1'b0;
		feed_if.valid   = 1'b0;
		feed_if.in_byte = 8'h00;
		feed_if.in_last = 1'b0;
		codec_dir       = DIR_ENCODE;
		clear_group();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_encode_directed();
		test_decode_directed();
		test_backpressure();
		test_random(340);

		settle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/b64_pkg.sv
rtl/core/b64_ifs.sv
rtl/core/b64_front.sv
rtl/core/b64_queue.sv
rtl/core/b64_back.sv
rtl/core/base64_stream_codec.sv
dv/tb.sv
